// ----- hw/rtl/gzhp_pkg.sv -----
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared codes, header constants and types of the gzip header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

   // byte role codes
   localparam logic [1:0] ROLE_HEADER = 2'd0;
   localparam logic [1:0] ROLE_BODY   = 2'd1;
   localparam logic [1:0] ROLE_REJECT = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_MAGIC  = 2'd1;
   localparam logic [1:0] ERR_METHOD = 2'd2;

   // header constants
   localparam logic [7:0] MAGIC_FIRST  = 8'h1f;
   localparam logic [7:0] MAGIC_SECOND = 8'h8b;
   localparam logic [7:0] METHOD_DEFL  = 8'h08;
   localparam logic [7:0] FLG_EXTRA    = 8'h04;
   localparam logic [7:0] FLG_NAME     = 8'h08;
   localparam logic [7:0] FLG_COMMENT  = 8'h10;
   localparam logic [7:0] FLG_HCRC     = 8'h02;

   typedef struct packed {
      logic [1:0] byte_role;
      logic [1:0] error_code;
      logic       header_end;
      logic [7:0] body_byte;
      logic [7:0] header_flags;
   } result_type;

endpackage

// ----- hw/rtl/gzhp_req_if.sv -----
// ----------------------------------------------------------------------------
// gzhp_req_if
// Input byte channel: valid/ready handshake with the stream byte and restart.
// ----------------------------------------------------------------------------
interface gzhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_stream;

   modport source (output valid, output data_byte, output new_stream, input ready);
   modport sink   (input valid, input data_byte, input new_stream, output ready);
endinterface

// ----- hw/rtl/gzhp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gzhp_rsp_if
// Result channel: valid/ready handshake with the per-byte classification.
// ----------------------------------------------------------------------------
interface gzhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] byte_role;
   logic [1:0] error_code;
   logic       header_end;
   logic [7:0] body_byte;
   logic [7:0] header_flags;

   modport source (output valid, output byte_role, output error_code, output header_end,
                   output body_byte, output header_flags, input ready);
   modport sink   (input valid, input byte_role, input error_code, input header_end,
                   input body_byte, input header_flags, output ready);
endinterface

// ----- hw/rtl/gzhp_parser.sv -----
// ----------------------------------------------------------------------------
// gzhp_parser
// Header walk state and the per-byte classification logic.
// ----------------------------------------------------------------------------
module gzhp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                new_stream,
   output gzhp_pkg::result_type result
);

   typedef enum logic [4:0] {
      PH_MAGIC1    = 5'd0,
      PH_MAGIC2    = 5'd1,
      PH_METHOD    = 5'd2,
      PH_FLAGS     = 5'd3,
      PH_MTIME1    = 5'd4,
      PH_MTIME2    = 5'd5,
      PH_MTIME3    = 5'd6,
      PH_MTIME4    = 5'd7,
      PH_XFL       = 5'd8,
      PH_OS        = 5'd9,
      PH_XLEN_LO   = 5'd10,
      PH_XLEN_HI   = 5'd11,
      PH_EXTRA     = 5'd12,
      PH_NAME      = 5'd13,
      PH_COMMENT   = 5'd14,
      PH_CRC1      = 5'd15,
      PH_CRC2      = 5'd16,
      PH_BODY      = 5'd17,
      PH_ERR_MAGIC = 5'd18,
      PH_ERR_METH  = 5'd19
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  flag_store_ff, flag_store_in;
   logic [15:0] extra_left_ff, extra_left_in;
   logic        error_seen_ff, error_seen_in;

   // state as seen by this byte, after an optional restart
   phase_type   cur_phase;
   logic [7:0]  cur_flags;
   logic [15:0] cur_extra;
   logic        cur_error;

   always_comb begin
      cur_phase = new_stream ? PH_MAGIC1 : phase_ff;
      cur_flags = new_stream ? 8'h00 : flag_store_ff;
      cur_extra = new_stream ? 16'h0000 : extra_left_ff;
      cur_error = new_stream ? 1'b0 : error_seen_ff;

      phase_in      = cur_phase;
      flag_store_in = cur_flags;
      extra_left_in = cur_extra;
      error_seen_in = cur_error;

      result.byte_role  = gzhp_pkg::ROLE_HEADER;
      result.error_code = gzhp_pkg::ERR_NONE;
      result.header_end = 1'b0;
      result.body_byte  = 8'h00;

      if (cur_error || cur_phase == PH_ERR_MAGIC || cur_phase == PH_ERR_METH) begin
         result.byte_role  = gzhp_pkg::ROLE_REJECT;
         result.error_code = (cur_phase == PH_ERR_METH) ? gzhp_pkg::ERR_METHOD
                                                         : gzhp_pkg::ERR_MAGIC;
      end else if (cur_phase == PH_BODY) begin
         result.byte_role = gzhp_pkg::ROLE_BODY;
         result.body_byte = data_byte;
      end else begin
         case (cur_phase)
            PH_MAGIC1, PH_MAGIC2: begin
               if (data_byte != ((cur_phase == PH_MAGIC1) ? gzhp_pkg::MAGIC_FIRST
                                                          : gzhp_pkg::MAGIC_SECOND)) begin
                  phase_in          = PH_ERR_MAGIC;
                  error_seen_in     = 1'b1;
                  result.byte_role  = gzhp_pkg::ROLE_REJECT;
                  result.error_code = gzhp_pkg::ERR_MAGIC;
               end else begin
                  phase_in = (cur_phase == PH_MAGIC1) ? PH_MAGIC2 : PH_METHOD;
               end
            end
            PH_METHOD: begin
               if (data_byte != gzhp_pkg::METHOD_DEFL) begin
                  phase_in          = PH_ERR_METH;
                  error_seen_in     = 1'b1;
                  result.byte_role  = gzhp_pkg::ROLE_REJECT;
                  result.error_code = gzhp_pkg::ERR_METHOD;
               end else begin
                  phase_in = PH_FLAGS;
               end
            end
            PH_FLAGS: begin
               flag_store_in = data_byte;
               phase_in      = PH_MTIME1;
            end
            PH_MTIME1: phase_in = PH_MTIME2;
            PH_MTIME2: phase_in = PH_MTIME3;
            PH_MTIME3: phase_in = PH_MTIME4;
            PH_MTIME4: phase_in = PH_XFL;
            PH_XFL:    phase_in = PH_OS;
            PH_OS:     phase_in = PH_XLEN_LO;
            PH_XLEN_LO: begin
               extra_left_in = {8'h00, data_byte};
               phase_in      = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
               extra_left_in = {data_byte, cur_extra[7:0]};
               phase_in      = (extra_left_in == 16'h0000) ? PH_NAME : PH_EXTRA;
            end
            PH_EXTRA: begin
               extra_left_in = cur_extra - 16'd1;
               phase_in      = (extra_left_in == 16'h0000) ? PH_NAME : PH_EXTRA;
            end
            PH_NAME:    phase_in = (data_byte == 8'h00) ? PH_COMMENT : PH_NAME;
            PH_COMMENT: phase_in = (data_byte == 8'h00) ? PH_CRC1 : PH_COMMENT;
            PH_CRC1:    phase_in = PH_CRC2;
            PH_CRC2:    phase_in = PH_BODY;
            default:    phase_in = cur_phase;
         endcase

         if (result.byte_role == gzhp_pkg::ROLE_HEADER) begin
            // skip optional parts whose flag bit is clear
            if (phase_in == PH_XLEN_LO && (flag_store_in & gzhp_pkg::FLG_EXTRA) == 8'h00)
               phase_in = PH_NAME;
            if (phase_in == PH_NAME && (flag_store_in & gzhp_pkg::FLG_NAME) == 8'h00)
               phase_in = PH_COMMENT;
            if (phase_in == PH_COMMENT && (flag_store_in & gzhp_pkg::FLG_COMMENT) == 8'h00)
               phase_in = PH_CRC1;
            if (phase_in == PH_CRC1 && (flag_store_in & gzhp_pkg::FLG_HCRC) == 8'h00)
               phase_in = PH_BODY;
            result.header_end = (phase_in == PH_BODY);
         end
      end

      result.header_flags = flag_store_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC1;
         flag_store_ff <= 8'h00;
         extra_left_ff <= 16'h0000;
         error_seen_ff <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         flag_store_ff <= flag_store_in;
         extra_left_ff <= extra_left_in;
         error_seen_ff <= error_seen_in;
      end
   end

endmodule

// ----- hw/rtl/gzip_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// gzip_header_parser_core
// Walks the gzip member header one byte per transfer and tags each byte.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                             handshake
//  req_chan  in   data_byte[8], new_stream[1]                         valid/ready
//  rsp_chan  out  byte_role[2], error_code[2], header_end[1],         valid/ready
//                 body_byte[8], header_flags[8]
//
//  One byte per cycle unless stalled; each result is registered on its transfer.
//  The parse state updates in the same cycle and feeds the result register.
//  A full result register that is not taken holds req_chan.ready low.
//  Synchronous reset returns the parser to the first magic byte.
// ----------------------------------------------------------------------------
module gzip_header_parser_core (
   input  logic      clock,
   input  logic      reset,
   gzhp_req_if.sink   req_chan,
   gzhp_rsp_if.source rsp_chan
);

   gzhp_pkg::result_type result;
   gzhp_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   gzhp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_chan.data_byte),
      .new_stream (req_chan.new_stream),
      .result     (result)
   );

   assign rsp_valid_in = accept ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.byte_role    = rsp_data_ff.byte_role;
   assign rsp_chan.error_code   = rsp_data_ff.error_code;
   assign rsp_chan.header_end   = rsp_data_ff.header_end;
   assign rsp_chan.body_byte    = rsp_data_ff.body_byte;
   assign rsp_chan.header_flags = rsp_data_ff.header_flags;

endmodule

// ----- hw/rtl/gzhp_checker.sv -----
// ----------------------------------------------------------------------------
// gzhp_checker
// Port-level checks on the result channel of the gzip header parser.
// ----------------------------------------------------------------------------
module gzhp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_byte_role,
   input logic [1:0] rsp_error_code,
   input logic       rsp_header_end,
   input logic [7:0] rsp_body_byte
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // rejected bytes carry an error code, others carry none
   a_err_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_byte_role == gzhp_pkg::ROLE_REJECT) ==
                     (rsp_error_code != gzhp_pkg::ERR_NONE)))
      else $error("error code does not match byte role");

   // header end is only ever flagged on a header byte
   a_hend_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_end |-> rsp_byte_role == gzhp_pkg::ROLE_HEADER)
      else $error("header end on a non-header byte");

   // body byte is zero unless the byte is passed on
   a_body_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role != gzhp_pkg::ROLE_BODY |-> rsp_body_byte == 8'h00)
      else $error("body byte set on a non-body byte");

endmodule

bind gzip_header_parser_core gzhp_checker u_gzhp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_byte_role  (rsp_chan.byte_role),
   .rsp_error_code (rsp_chan.error_code),
   .rsp_header_end (rsp_chan.header_end),
   .rsp_body_byte  (rsp_chan.body_byte)
);

// ----- tb/gzip_header_parser_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzip_header_parser_core_test
// Byte-stream regression for the gzip member header parser. A directed opening
// covers the field extremes, both error kinds, a full header with every
// optional part and restarts. It is followed by random members, broken
// members and noise under random back-pressure. Every result transfer is
// checked field by field against a cycle-free model of the header walk.
// ----------------------------------------------------------------------------
module gzip_header_parser_core_test;

   localparam int OPENING_ITEMS = 25;
   localparam int RANDOM_ITEMS  = 925;
   localparam int CALM_TAIL     = 150;
   localparam int HOLD_CYCLES   = 150;

   typedef enum logic [4:0] {
      HP_MAGIC1    = 5'd0,
      HP_MAGIC2    = 5'd1,
      HP_METHOD    = 5'd2,
      HP_FLAGS     = 5'd3,
      HP_MTIME0    = 5'd4,
      HP_MTIME1    = 5'd5,
      HP_MTIME2    = 5'd6,
      HP_MTIME3    = 5'd7,
      HP_XFL       = 5'd8,
      HP_OS        = 5'd9,
      HP_XLEN_LO   = 5'd10,
      HP_XLEN_HI   = 5'd11,
      HP_EXTRA     = 5'd12,
      HP_NAME      = 5'd13,
      HP_COMMENT   = 5'd14,
      HP_CRC1      = 5'd15,
      HP_CRC2      = 5'd16,
      HP_BODY      = 5'd17,
      HP_ERR_MAGIC = 5'd18,
      HP_ERR_METHOD = 5'd19
   } hdr_phase_type;

   // Tracks the header walk and holds the byte tags still owed by the block.
   class tag_scoreboard;
      gzhp_pkg::result_type tag_q[$];
      hdr_phase_type        phase;
      logic [7:0]           flags;
      logic [15:0]          extra_left;
      logic                 err_seen;
      int                   faults;

      function new();
         clear();
         faults = 0;
      endfunction

      function void clear();
         phase      = HP_MAGIC1;
         flags      = 8'h00;
         extra_left = 16'h0000;
         err_seen   = 1'b0;
      endfunction

      function int pending();
         return tag_q.size();
      endfunction

      function void note_byte(input logic [7:0] b, input logic restart);
         gzhp_pkg::result_type tag;
         hdr_phase_type        nxt;
         logic [7:0]           magic;
         if (restart) clear();
         tag = '0;
         nxt = phase;
         if (err_seen || phase == HP_ERR_MAGIC || phase == HP_ERR_METHOD) begin
            tag.byte_role  = gzhp_pkg::ROLE_REJECT;
            tag.error_code = (phase == HP_ERR_METHOD) ? gzhp_pkg::ERR_METHOD
                                                      : gzhp_pkg::ERR_MAGIC;
         end else if (phase == HP_BODY) begin
            tag.byte_role = gzhp_pkg::ROLE_BODY;
            tag.body_byte = b;
         end else begin
            case (phase)
               HP_MAGIC1, HP_MAGIC2: begin
                  magic = (phase == HP_MAGIC1) ? gzhp_pkg::MAGIC_FIRST
                                               : gzhp_pkg::MAGIC_SECOND;
                  if (b != magic) begin
                     nxt            = HP_ERR_MAGIC;
                     err_seen       = 1'b1;
                     tag.byte_role  = gzhp_pkg::ROLE_REJECT;
                     tag.error_code = gzhp_pkg::ERR_MAGIC;
                  end else begin
                     nxt = hdr_phase_type'(phase + 5'd1);
                  end
               end
               HP_METHOD: begin
                  if (b != gzhp_pkg::METHOD_DEFL) begin
                     nxt            = HP_ERR_METHOD;
                     err_seen       = 1'b1;
                     tag.byte_role  = gzhp_pkg::ROLE_REJECT;
                     tag.error_code = gzhp_pkg::ERR_METHOD;
                  end else begin
                     nxt = HP_FLAGS;
                  end
               end
               HP_FLAGS: begin
                  flags = b;
                  nxt   = HP_MTIME0;
               end
               HP_XLEN_LO: begin
                  extra_left = {8'h00, b};
                  nxt        = HP_XLEN_HI;
               end
               HP_XLEN_HI: begin
                  extra_left = {b, extra_left[7:0]};
                  nxt        = (extra_left == 16'h0000) ? HP_NAME : HP_EXTRA;
               end
               HP_EXTRA: begin
                  extra_left = extra_left - 16'd1;
                  nxt        = (extra_left == 16'h0000) ? HP_NAME : HP_EXTRA;
               end
               HP_NAME, HP_COMMENT:
                  nxt = (b == 8'h00) ? hdr_phase_type'(phase + 5'd1) : phase;
               HP_CRC1: nxt = HP_CRC2;
               HP_CRC2: nxt = HP_BODY;
               default: nxt = hdr_phase_type'(phase + 5'd1);
            endcase
            if (tag.byte_role == gzhp_pkg::ROLE_HEADER) begin
               // parts whose flag is clear take no bytes
               if (nxt == HP_XLEN_LO && (flags & gzhp_pkg::FLG_EXTRA) == 8'h00)
                  nxt = HP_NAME;
               if (nxt == HP_NAME && (flags & gzhp_pkg::FLG_NAME) == 8'h00)
                  nxt = HP_COMMENT;
               if (nxt == HP_COMMENT && (flags & gzhp_pkg::FLG_COMMENT) == 8'h00)
                  nxt = HP_CRC1;
               if (nxt == HP_CRC1 && (flags & gzhp_pkg::FLG_HCRC) == 8'h00)
                  nxt = HP_BODY;
               tag.header_end = (nxt == HP_BODY);
            end
         end
         phase            = nxt;
         tag.header_flags = flags;
         tag_q.push_back(tag);
      endfunction

      function void check_tag(input gzhp_pkg::result_type got);
         gzhp_pkg::result_type want;
         if (tag_q.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: role=%0d err=%0d end=%0b body=%02h flags=%02h",
                        got.byte_role, got.error_code, got.header_end, got.body_byte,
                        got.header_flags);
            return;
         end
         want = tag_q.pop_front();
         if (got.byte_role !== want.byte_role || got.error_code !== want.error_code ||
             got.header_end !== want.header_end || got.body_byte !== want.body_byte ||
             got.header_flags !== want.header_flags) begin
            faults++;
            if (faults <= 10)
               $display({"mismatch: exp role=%0d err=%0d end=%0b body=%02h flags=%02h",
                         " / got role=%0d err=%0d end=%0b body=%02h flags=%02h"},
                        want.byte_role, want.error_code, want.header_end, want.body_byte,
                        want.header_flags, got.byte_role, got.error_code, got.header_end,
                        got.body_byte, got.header_flags);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   tx_calm;
   bit   rx_calm;
   bit   hold_req;
   int   items_sent;
   int   big_extras;

   tag_scoreboard sb = new();

   gzhp_req_if req_chan ();
   gzhp_rsp_if rsp_chan ();

   gzip_header_parser_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // one byte onto the input channel, optionally after an idle burst
   task automatic send_byte(input logic [7:0] b, input logic restart);
      int gap;
      if (!tx_calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      = 1'b1;
      req_chan.data_byte  = b;
      req_chan.new_stream = restart;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_byte(b, restart);
      items_sent++;
   endtask

   // A gzip member with random content; a broken one has a bad magic or method
   // byte or is cut short. Either way up to 12 trailing bytes follow.
   task automatic send_member(input bit broken);
      logic [7:0] hdr[$];
      logic [7:0] flg;
      logic [15:0] xlen;
      int pos;
      int keep;
      flg = 8'($urandom_range(0, 255));
      hdr = '{gzhp_pkg::MAGIC_FIRST, gzhp_pkg::MAGIC_SECOND, gzhp_pkg::METHOD_DEFL, flg};
      repeat (6) hdr.push_back(8'($urandom_range(0, 255)));
      if ((flg & gzhp_pkg::FLG_EXTRA) != 8'h00) begin
         xlen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 255))
                                             : 16'($urandom_range(0, 6));
         if (big_extras < 4 && $urandom_range(0, 29) == 0) begin
            xlen = xlen + 16'd256;
            big_extras++;
         end
         hdr.push_back(xlen[7:0]);
         hdr.push_back(xlen[15:8]);
         repeat (xlen) hdr.push_back(8'($urandom_range(0, 255)));
      end
      if ((flg & gzhp_pkg::FLG_NAME) != 8'h00) begin
         repeat ($urandom_range(0, 5)) hdr.push_back(8'($urandom_range(1, 255)));
         hdr.push_back(8'h00);
      end
      if ((flg & gzhp_pkg::FLG_COMMENT) != 8'h00) begin
         repeat ($urandom_range(0, 5)) hdr.push_back(8'($urandom_range(1, 255)));
         hdr.push_back(8'h00);
      end
      if ((flg & gzhp_pkg::FLG_HCRC) != 8'h00)
         repeat (2) hdr.push_back(8'($urandom_range(0, 255)));
      if (broken) begin
         if ($urandom_range(0, 1) == 1) begin
            pos      = $urandom_range(0, 2);
            hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
         end else begin
            keep = $urandom_range(1, hdr.size() - 1);
            while (hdr.size() > keep) void'(hdr.pop_back());
         end
      end
      repeat ($urandom_range(0, 12)) hdr.push_back(8'($urandom_range(0, 255)));
      foreach (hdr[i]) send_byte(hdr[i], i == 0);
   endtask

   initial begin : rsp_stall
      int gap;
      bit held;
      held           = 1'b0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req && !held) begin
            held           = 1'b1;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready = 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      gzhp_pkg::result_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.byte_role    = rsp_chan.byte_role;
         got.error_code   = rsp_chan.error_code;
         got.header_end   = rsp_chan.header_end;
         got.body_byte    = rsp_chan.body_byte;
         got.header_flags = rsp_chan.header_flags;
         sb.check_tag(got);
      end
   end

   initial begin : stimulus
      logic [7:0] opening[$];
      int pick;
      bit jammed;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = 8'h00;
      req_chan.new_stream = 1'b0;
      tx_calm             = 1'b0;
      rx_calm             = 1'b0;
      hold_req            = 1'b0;
      items_sent          = 0;
      big_extras          = 0;
      jammed              = 1'b0;
      // after reset, no restart: every optional part plus reserved flag bits,
      // zero extra length, empty strings, then one body byte
      opening = '{8'h1f, 8'h8b, 8'h08, 8'hfe,
                  8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening[i]) send_byte(opening[i], 1'b0);
      send_byte(8'h00, 1'b1);                    // bad first magic
      send_byte(gzhp_pkg::MAGIC_FIRST, 1'b0);    // rejected, error sticks
      send_byte(gzhp_pkg::MAGIC_FIRST, 1'b1);
      send_byte(gzhp_pkg::MAGIC_SECOND, 1'b0);
      send_byte(8'h00, 1'b0);                    // method not deflate
      send_byte(gzhp_pkg::METHOD_DEFL, 1'b0);
      send_byte(gzhp_pkg::MAGIC_FIRST, 1'b1);
      send_byte(8'hff, 1'b0);                    // bad second magic

      while (items_sent < OPENING_ITEMS + RANDOM_ITEMS) begin
         if (items_sent >= OPENING_ITEMS + RANDOM_ITEMS - CALM_TAIL) begin
            tx_calm = 1'b1;
            rx_calm = 1'b1;
         end else begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
         end
         if (!jammed && items_sent >= 300) begin
            // long receiver hold-off while bytes keep coming
            jammed   = 1'b1;
            tx_calm  = 1'b1;
            hold_req = 1'b1;
            repeat (3) send_member(1'b0);
         end
         pick = $urandom_range(0, 19);
         if (pick < 15)
            send_member(1'b0);
         else if (pick < 17)
            send_member(1'b1);
         else
            repeat ($urandom_range(1, 8))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
